// ----- hw/rtl/cv3_pkg.sv -----
// Shared constants and types for the 3x3 zero-padded convolution core.
`timescale 1ns / 1ps

package cv3_pkg;

  localparam int MAX_SIZE = 1024;
  localparam int KSIZE    = 3;
  localparam int PIX_W    = 16;
  localparam int COEF_W   = 8;
  localparam int PROD_W   = PIX_W + COEF_W;
  localparam int OUT_W    = 27;
  localparam int ADDR_W   = $clog2(MAX_SIZE);
  localparam int SIZE_W   = 11;
  localparam int ROW_W    = ADDR_W + 1;
  localparam int KROW_W   = KSIZE * COEF_W;
  localparam int LS_W     = 2 * PIX_W;
  localparam int CFG_IDX_W = 2;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_TOP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MID    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_BOTTOM = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE    = 2'd3;

  typedef struct packed {
    logic emit;
    logic last;
    logic mask_top;
    logic mask_bottom;
    logic mask_left;
    logic mask_right;
  } ctl_t;

endpackage

// ----- hw/rtl/cv3_cell.sv -----
// One window cell: holds a pixel, passes it to its left neighbor and forms a masked product.
`timescale 1ns / 1ps

module cv3_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              shift_en_i,
  input  logic signed [cv3_pkg::PIX_W-1:0]  pix_i,
  input  logic signed [cv3_pkg::COEF_W-1:0] coef_i,
  input  logic                              mask_i,
  input  logic                              prod_en_i,
  output logic signed [cv3_pkg::PIX_W-1:0]  pix_o,
  output logic signed [cv3_pkg::PROD_W-1:0] prod_o
);

  logic signed [cv3_pkg::PIX_W-1:0]  pix_q;
  logic signed [cv3_pkg::PROD_W-1:0] prod_d;
  logic signed [cv3_pkg::PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q <= '0;
    end else if (shift_en_i) begin
      pix_q <= pix_i;
    end
  end

  always_comb begin
    if (mask_i) begin
      prod_d = '0;
    end else begin
      prod_d = pix_q * coef_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_en_i) begin
      prod_q <= prod_d;
    end
  end

  assign pix_o  = pix_q;
  assign prod_o = prod_q;

endmodule

// ----- hw/rtl/cv3_line_store.sv -----
// Line store holding the two previous image rows per column, with write-to-read forwarding.
`timescale 1ns / 1ps

module cv3_line_store (
  input  logic                         clk_i,
  input  logic                         rd_en_i,
  input  logic [cv3_pkg::ADDR_W-1:0]   rd_addr_i,
  input  logic                         wr_en_i,
  input  logic [cv3_pkg::ADDR_W-1:0]   wr_addr_i,
  input  logic [cv3_pkg::LS_W-1:0]     wr_data_i,
  output logic [cv3_pkg::LS_W-1:0]     rd_data_o
);

  logic [cv3_pkg::LS_W-1:0] mem_q [cv3_pkg::MAX_SIZE];
  logic [cv3_pkg::LS_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- hw/rtl/conv2d_3x3_zero_padded_core.sv -----
// Top level of the 3x3 zero-padded convolution core.
//
//   Channel  | Handshake                  | Payload
//   ---------+----------------------------+------------------------------
//   input    | in_valid_i / in_ready_o    | pixel_i, is_flush_i
//   output   | out_valid_o / out_ready_i  | conv_value_o, last_o
//   config   | cfg_we_i                   | cfg_idx_i, cfg_data_i
//
// One item is taken per cycle while in_ready_o is high.
// The line store read, the window shift, the cell products and two adder
// levels form the pipeline, and an eight-entry result queue absorbs stalls.
// Input ready drops only when eight results are pending in pipeline and queue.
// Reset clears counters, window and queue; the line store needs no clearing.
`timescale 1ns / 1ps

module conv2d_3x3_zero_padded_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [cv3_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [cv3_pkg::KROW_W-1:0]         cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [cv3_pkg::PIX_W-1:0]   pixel_i,
  input  logic                               is_flush_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [cv3_pkg::OUT_W-1:0]   conv_value_o,
  output logic                               last_o
);

  localparam int K = cv3_pkg::KSIZE;

  logic [cv3_pkg::KROW_W-1:0] kernel_q [K];
  logic [cv3_pkg::ADDR_W-1:0] last_idx_q;
  logic [cv3_pkg::ADDR_W-1:0] col_q, col_d;
  logic [cv3_pkg::ROW_W-1:0]  row_q, row_d;
  logic [cv3_pkg::SIZE_W-1:0] size_raw;
  logic [cv3_pkg::ADDR_W-1:0] size_idx;

  logic                       accept;
  logic [cv3_pkg::ADDR_W-1:0] c_a;
  logic [cv3_pkg::ROW_W-1:0]  orow;
  logic [cv3_pkg::ADDR_W-1:0] ocol;
  logic                       hit;
  cv3_pkg::ctl_t              ctl_a;

  logic                             s1_vld_q;
  cv3_pkg::ctl_t                    s1_ctl_q;
  logic [cv3_pkg::ADDR_W-1:0]       s1_addr_q;
  logic signed [cv3_pkg::PIX_W-1:0] s1_pix_q;
  logic [cv3_pkg::LS_W-1:0]         ls_rd_data;
  logic [cv3_pkg::LS_W-1:0]         ls_wr_data;

  logic          s2_vld_q;
  cv3_pkg::ctl_t s2_ctl_q;
  logic          s3_vld_q;
  logic          s3_last_q;
  logic          s4_vld_q;
  logic          s4_last_q;

  logic signed [cv3_pkg::PIX_W-1:0]  col_in [K];
  logic signed [cv3_pkg::PIX_W-1:0]  pix    [K][K];
  logic signed [cv3_pkg::PROD_W-1:0] prod   [K][K];
  logic                              mask   [K][K];
  logic signed [cv3_pkg::OUT_W-1:0]  row_sum_d [K];
  logic signed [cv3_pkg::OUT_W-1:0]  row_sum_q [K];
  logic signed [cv3_pkg::OUT_W-1:0]  total;

  logic signed [cv3_pkg::OUT_W-1:0] fifo_val_q  [cv3_pkg::FIFO_DEPTH];
  logic                             fifo_last_q [cv3_pkg::FIFO_DEPTH];
  logic [cv3_pkg::FIFO_AW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [cv3_pkg::FIFO_AW:0]        fifo_cnt_q, pend_q;
  logic                             pop;

  // Configuration and position counters.
  assign size_raw = cfg_data_i[cv3_pkg::SIZE_W-1:0];

  always_comb begin
    if (size_raw == '0) begin
      size_idx = '0;
    end else if (size_raw > cv3_pkg::SIZE_W'(cv3_pkg::MAX_SIZE)) begin
      size_idx = cv3_pkg::ADDR_W'(cv3_pkg::MAX_SIZE - 1);
    end else begin
      size_idx = cv3_pkg::ADDR_W'(size_raw - cv3_pkg::SIZE_W'(1));
    end
  end

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = pend_q < (cv3_pkg::FIFO_AW + 1)'(cv3_pkg::FIFO_DEPTH);

  always_comb begin
    c_a   = (col_q > last_idx_q) ? '0 : col_q;
    orow  = '0;
    ocol  = '0;
    hit   = 1'b0;
    if ((c_a != '0) && (row_q != '0)) begin
      orow = row_q - cv3_pkg::ROW_W'(1);
      ocol = c_a - cv3_pkg::ADDR_W'(1);
      hit  = 1'b1;
    end else if ((c_a == '0) && (row_q >= cv3_pkg::ROW_W'(2))) begin
      orow = row_q - cv3_pkg::ROW_W'(2);
      ocol = last_idx_q;
      hit  = 1'b1;
    end
    ctl_a.emit        = hit && (orow <= cv3_pkg::ROW_W'(last_idx_q));
    ctl_a.last        = (orow == cv3_pkg::ROW_W'(last_idx_q)) && (ocol == last_idx_q);
    ctl_a.mask_top    = (orow == '0);
    ctl_a.mask_bottom = (orow == cv3_pkg::ROW_W'(last_idx_q));
    ctl_a.mask_left   = (ocol == '0);
    ctl_a.mask_right  = (ocol == last_idx_q);

    if (ctl_a.emit && ctl_a.last) begin
      col_d = '0;
      row_d = '0;
    end else if (c_a == last_idx_q) begin
      col_d = '0;
      row_d = row_q + cv3_pkg::ROW_W'(1);
    end else begin
      col_d = c_a + cv3_pkg::ADDR_W'(1);
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_q[0] <= '0;
      kernel_q[1] <= '0;
      kernel_q[2] <= '0;
      last_idx_q  <= cv3_pkg::ADDR_W'(7);
      col_q       <= '0;
      row_q       <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cv3_pkg::CFG_KERNEL_TOP:    kernel_q[0] <= cfg_data_i;
        cv3_pkg::CFG_KERNEL_MID:    kernel_q[1] <= cfg_data_i;
        cv3_pkg::CFG_KERNEL_BOTTOM: kernel_q[2] <= cfg_data_i;
        cv3_pkg::CFG_IMAGE_SIZE: begin
          last_idx_q <= size_idx;
          col_q      <= '0;
          row_q      <= '0;
        end
        default: ;
      endcase
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Stage one: line store read data arrives, the store is rewritten; later stages carry valid and last.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s1_ctl_q  <= '0;
      s1_addr_q <= '0;
      s1_pix_q  <= '0;
      s2_vld_q  <= 1'b0;
      s2_ctl_q  <= '0;
      s3_vld_q  <= 1'b0;
      s3_last_q <= 1'b0;
      s4_vld_q  <= 1'b0;
      s4_last_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
      if (accept) begin
        s1_ctl_q  <= ctl_a;
        s1_addr_q <= c_a;
        s1_pix_q  <= is_flush_i ? '0 : pixel_i;
      end
      s2_vld_q <= s1_vld_q && s1_ctl_q.emit;
      if (s1_vld_q) begin
        s2_ctl_q <= s1_ctl_q;
      end
      s3_vld_q  <= s2_vld_q;
      s3_last_q <= s2_ctl_q.last;
      s4_vld_q  <= s3_vld_q;
      s4_last_q <= s3_last_q;
    end
  end

  assign ls_wr_data = {ls_rd_data[cv3_pkg::PIX_W-1:0], s1_pix_q};

  cv3_line_store u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (c_a),
    .wr_en_i   (s1_vld_q),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (ls_wr_data),
    .rd_data_o (ls_rd_data)
  );

  assign col_in[0] = ls_rd_data[cv3_pkg::LS_W-1:cv3_pkg::PIX_W];
  assign col_in[1] = ls_rd_data[cv3_pkg::PIX_W-1:0];
  assign col_in[2] = s1_pix_q;

  // Window: three chains of three cells, newest column on the right.
  for (genvar y = 0; y < K; y++) begin : g_row
    for (genvar x = 0; x < K; x++) begin : g_col
      logic signed [cv3_pkg::PIX_W-1:0] feed;
      if (x == K - 1) begin : g_edge
        assign feed = col_in[y];
      end else begin : g_inner
        assign feed = pix[y][x+1];
      end

      assign mask[y][x] = ((y == 0) && s2_ctl_q.mask_top) ||
                          ((y == K - 1) && s2_ctl_q.mask_bottom) ||
                          ((x == 0) && s2_ctl_q.mask_left) ||
                          ((x == K - 1) && s2_ctl_q.mask_right);

      cv3_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .shift_en_i (s1_vld_q),
        .pix_i      (feed),
        .coef_i     (kernel_q[y][x*cv3_pkg::COEF_W +: cv3_pkg::COEF_W]),
        .mask_i     (mask[y][x]),
        .prod_en_i  (s2_vld_q),
        .pix_o      (pix[y][x]),
        .prod_o     (prod[y][x])
      );
    end
  end

  always_comb begin
    for (int y = 0; y < K; y++) begin
      row_sum_d[y] = cv3_pkg::OUT_W'(prod[y][0]) + cv3_pkg::OUT_W'(prod[y][1]) +
                     cv3_pkg::OUT_W'(prod[y][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_vld_q) begin
      row_sum_q[0] <= row_sum_d[0];
      row_sum_q[1] <= row_sum_d[1];
      row_sum_q[2] <= row_sum_d[2];
    end
  end

  assign total = row_sum_q[0] + row_sum_q[1] + row_sum_q[2];

  // Result queue and pending-result credit.
  assign pop          = out_valid_o && out_ready_i;
  assign out_valid_o  = fifo_cnt_q != '0;
  assign conv_value_o = fifo_val_q[rd_ptr_q];
  assign last_o       = fifo_last_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (s4_vld_q) begin
      fifo_val_q[wr_ptr_q]  <= total;
      fifo_last_q[wr_ptr_q] <= s4_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
      pend_q     <= '0;
    end else begin
      if (s4_vld_q) begin
        wr_ptr_q <= wr_ptr_q + cv3_pkg::FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + cv3_pkg::FIFO_AW'(1);
      end
      fifo_cnt_q <= fifo_cnt_q + (cv3_pkg::FIFO_AW + 1)'(s4_vld_q)
                               - (cv3_pkg::FIFO_AW + 1)'(pop);
      pend_q     <= pend_q + (cv3_pkg::FIFO_AW + 1)'(accept && ctl_a.emit)
                           - (cv3_pkg::FIFO_AW + 1)'(pop);
    end
  end

endmodule

// ----- tb/conv2d_3x3_zero_padded_core_test.sv -----
// Self-checking testbench for the 3x3 zero-padded convolution core.
`timescale 1ns / 1ps

module conv2d_3x3_zero_padded_core_test;
  import cv3_pkg::*;

  localparam int LATENCY      = 5;
  localparam int RANDOM_ITEMS = 540;
  localparam int DIR_ROWS     = 31;

  localparam logic signed [PIX_W-1:0] PIX_MAX = 16'sh7FFF;
  localparam logic signed [PIX_W-1:0] PIX_MIN = 16'sh8000;
  localparam logic [KROW_W-1:0]       K_MIN   = 24'h808080;
  localparam logic [KROW_W-1:0]       K_NONE  = 24'h000000;

  localparam logic signed [OUT_W-1:0] SUM_CORNER = 27'sd16777216;
  localparam logic signed [OUT_W-1:0] SUM_EDGE   = 27'sd25165824;
  localparam logic signed [OUT_W-1:0] SUM_FULL   = 27'sd37748736;

  typedef struct packed {
    logic signed [OUT_W-1:0] value;
    logic                    last;
  } conv_result_t;

  typedef enum logic {STEP_ITEM, STEP_WRITE} step_kind_e;
  typedef enum int {SHAPE_FULL, SHAPE_CUT, SHAPE_NOISE} shape_e;

  typedef struct packed {
    step_kind_e           kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [KROW_W-1:0]    data;
    logic signed [PIX_W-1:0] pix;
    logic                 flush;
    logic                 fixed;
    conv_result_t         res;
  } dir_step_t;

  // Default size with a cleared kernel, then a one-pixel image, then a 3x3 image
  // of the most negative pixel under the most negative kernel.
  localparam dir_step_t DIRECTED [DIR_ROWS] = '{
    '{STEP_ITEM,  CFG_KERNEL_TOP,    K_NONE, PIX_MAX, 1'b0, 1'b0, '0},
    '{STEP_ITEM,  CFG_KERNEL_TOP,    K_NONE, PIX_MIN, 1'b0, 1'b0, '0},
    '{STEP_ITEM,  CFG_KERNEL_TOP,    K_NONE, PIX_MAX, 1'b0, 1'b0, '0},
    '{STEP_ITEM,  CFG_KERNEL_TOP,    K_NONE, PIX_MIN, 1'b0, 1'b0, '0},
    '{STEP_ITEM,  CFG_KERNEL_TOP,    K_NONE, PIX_MAX, 1'b0, 1'b0, '0},
    '{STEP_ITEM,  CFG_KERNEL_TOP,    K_NONE, PIX_MIN, 1'b0, 1'b0, '0},
    '{STEP_ITEM,  CFG_KERNEL_TOP,    K_NONE, PIX_MAX, 1'b0, 1'b0, '0},
    '{STEP_ITEM,  CFG_KERNEL_TOP,    K_NONE, PIX_MIN, 1'b0, 1'b0, '0},
    '{STEP_ITEM,  CFG_KERNEL_TOP,    K_NONE, PIX_MAX, 1'b0, 1'b0, '0},
    '{STEP_ITEM,  CFG_KERNEL_TOP,    K_NONE, PIX_MAX, 1'b0, 1'b1, '{27'sd0, 1'b0}},
    '{STEP_WRITE, CFG_IMAGE_SIZE,    K_NONE, PIX_MAX, 1'b0, 1'b0, '0},
    '{STEP_WRITE, CFG_KERNEL_TOP,    K_MIN,  PIX_MAX, 1'b0, 1'b0, '0},
    '{STEP_WRITE, CFG_KERNEL_MID,    K_MIN,  PIX_MAX, 1'b0, 1'b0, '0},
    '{STEP_WRITE, CFG_KERNEL_BOTTOM, K_MIN,  PIX_MAX, 1'b0, 1'b0, '0},
    '{STEP_ITEM,  CFG_KERNEL_TOP,    K_NONE, PIX_MAX, 1'b1, 1'b0, '0},
    '{STEP_ITEM,  CFG_KERNEL_TOP,    K_NONE, PIX_MIN, 1'b0, 1'b0, '0},
    '{STEP_ITEM,  CFG_KERNEL_TOP,    K_NONE, PIX_MIN, 1'b0, 1'b1, '{27'sd0, 1'b1}},
    '{STEP_WRITE, CFG_IMAGE_SIZE,    24'd3,  PIX_MAX, 1'b0, 1'b0, '0},
    '{STEP_ITEM,  CFG_KERNEL_TOP,    K_NONE, PIX_MIN, 1'b0, 1'b0, '0},
    '{STEP_ITEM,  CFG_KERNEL_TOP,    K_NONE, PIX_MIN, 1'b0, 1'b0, '0},
    '{STEP_ITEM,  CFG_KERNEL_TOP,    K_NONE, PIX_MIN, 1'b0, 1'b0, '0},
    '{STEP_ITEM,  CFG_KERNEL_TOP,    K_NONE, PIX_MIN, 1'b0, 1'b0, '0},
    '{STEP_ITEM,  CFG_KERNEL_TOP,    K_NONE, PIX_MIN, 1'b0, 1'b1, '{SUM_CORNER, 1'b0}},
    '{STEP_ITEM,  CFG_KERNEL_TOP,    K_NONE, PIX_MIN, 1'b0, 1'b1, '{SUM_EDGE, 1'b0}},
    '{STEP_ITEM,  CFG_KERNEL_TOP,    K_NONE, PIX_MIN, 1'b0, 1'b1, '{SUM_CORNER, 1'b0}},
    '{STEP_ITEM,  CFG_KERNEL_TOP,    K_NONE, PIX_MIN, 1'b0, 1'b1, '{SUM_EDGE, 1'b0}},
    '{STEP_ITEM,  CFG_KERNEL_TOP,    K_NONE, PIX_MIN, 1'b0, 1'b1, '{SUM_FULL, 1'b0}},
    '{STEP_ITEM,  CFG_KERNEL_TOP,    K_NONE, PIX_MAX, 1'b1, 1'b1, '{SUM_EDGE, 1'b0}},
    '{STEP_ITEM,  CFG_KERNEL_TOP,    K_NONE, PIX_MAX, 1'b0, 1'b1, '{SUM_CORNER, 1'b0}},
    '{STEP_ITEM,  CFG_KERNEL_TOP,    K_NONE, PIX_MIN, 1'b1, 1'b1, '{SUM_EDGE, 1'b0}},
    '{STEP_ITEM,  CFG_KERNEL_TOP,    K_NONE, PIX_MAX, 1'b0, 1'b1, '{SUM_CORNER, 1'b1}}
  };

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx   = CFG_KERNEL_TOP;
  logic [KROW_W-1:0]       cfg_data  = '0;
  logic                    in_valid  = 1'b0;
  logic                    in_ready;
  logic signed [PIX_W-1:0] pixel     = '0;
  logic                    is_flush  = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [OUT_W-1:0] conv_value;
  logic                    last;

  int send_idle_pct = 37;
  int recv_idle_pct = 49;
  int error_count   = 0;

  conv_result_t pending_results [$];
  conv_result_t oldest;

  logic [KROW_W-1:0]       kernel_q [KSIZE] = '{default: '0};
  logic [SIZE_W-1:0]       image_size_q = 11'd8;
  logic signed [PIX_W-1:0] upper_line [MAX_SIZE];
  logic signed [PIX_W-1:0] lower_line [MAX_SIZE];
  logic signed [PIX_W-1:0] window_q [KSIZE][KSIZE] = '{default: '0};
  int                      col_q = 0;
  int                      row_q = 0;

  conv2d_3x3_zero_padded_core u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .pixel_i      (pixel),
    .is_flush_i   (is_flush),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .conv_value_o (conv_value),
    .last_o       (last)
  );

  always #1 clk = ~clk;

  function automatic int effective_size();
    if (image_size_q == '0) return 1;
    if (image_size_q > MAX_SIZE) return MAX_SIZE;
    return int'(image_size_q);
  endfunction

  task automatic predict_conv(input logic signed [PIX_W-1:0] pix, input logic flush,
                              output bit hit, output conv_result_t res);
    int size, c, r, orow, ocol, y, x;
    logic signed [PIX_W-1:0] v, top, mid;
    longint sum;
    size = effective_size();
    c = col_q;
    r = row_q;
    v = flush ? '0 : pix;
    hit = 1'b0;
    res = '0;
    orow = 0;
    ocol = 0;
    if (c >= size) c = 0;
    top = upper_line[c];
    mid = lower_line[c];
    upper_line[c] = mid;
    lower_line[c] = v;
    for (y = 0; y < KSIZE; y++) begin
      window_q[y][0] = window_q[y][1];
      window_q[y][1] = window_q[y][2];
    end
    window_q[0][2] = top;
    window_q[1][2] = mid;
    window_q[2][2] = v;
    if (c >= 1 && r >= 1) begin
      orow = r - 1;
      ocol = c - 1;
      hit = 1'b1;
    end else if (c == 0 && r >= 2) begin
      orow = r - 2;
      ocol = size - 1;
      hit = 1'b1;
    end
    if (hit && orow >= size) hit = 1'b0;
    if (c + 1 >= size) begin
      c = 0;
      r++;
    end else begin
      c++;
    end
    if (hit) begin
      sum = 0;
      for (y = 0; y < KSIZE; y++) begin
        if (orow + y - 1 < 0 || orow + y - 1 >= size) continue;
        for (x = 0; x < KSIZE; x++) begin
          if (ocol + x - 1 < 0 || ocol + x - 1 >= size) continue;
          sum += longint'(window_q[y][x]) *
                 longint'($signed(kernel_q[y][x*COEF_W +: COEF_W]));
        end
      end
      res.value = OUT_W'(sum);
      res.last  = (orow == size - 1) && (ocol == size - 1);
      if (res.last) begin
        c = 0;
        r = 0;
      end
    end
    col_q = c & 'h3FF;
    row_q = r & 'h7FF;
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [KROW_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      CFG_KERNEL_TOP:    kernel_q[0] = data;
      CFG_KERNEL_MID:    kernel_q[1] = data;
      CFG_KERNEL_BOTTOM: kernel_q[2] = data;
      CFG_IMAGE_SIZE: begin
        image_size_q = data[SIZE_W-1:0];
        window_q = '{default: '0};
        col_q = 0;
        row_q = 0;
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic send_pixel(input logic signed [PIX_W-1:0] pix, input logic flush,
                            input logic fixed, input conv_result_t fixed_res);
    bit hit;
    conv_result_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    pixel    <= pix;
    is_flush <= flush;
    do @(posedge clk); while (!in_ready);
    predict_conv(pix, flush, hit, res);
    if (fixed) pending_results.push_back(fixed_res);
    else if (hit) pending_results.push_back(res);
    @(negedge clk);
  endtask

  function automatic logic signed [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0:       return PIX_MAX;
      1:       return PIX_MIN;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  function automatic logic [KROW_W-1:0] pick_kernel();
    case ($urandom_range(0, 7))
      0:       return K_NONE;
      1:       return 24'h7F7F7F;
      2:       return K_MIN;
      default: return KROW_W'($urandom);
    endcase
  endfunction

  function automatic int pick_side();
    int roll;
    roll = $urandom_range(0, 15);
    if (roll == 0) return 0;
    if (roll < 3) return $urandom_range(9, 20);
    return $urandom_range(1, 8);
  endfunction

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: value %0d last %0b", $time, conv_value, last);
        error_count++;
      end else begin
        oldest = pending_results.pop_front();
        if (conv_value !== oldest.value) begin
          $display("%0t: conv_value mismatch: expected %0d actual %0d",
                   $time, oldest.value, conv_value);
          error_count++;
        end
        if (last !== oldest.last) begin
          $display("%0t: last mismatch: expected %0b actual %0b",
                   $time, oldest.last, last);
          error_count++;
        end
      end
    end
  end

  initial begin : stimulus
    int items_sent, side, count, p;
    bit restart_due, big_done;
    logic flush;
    shape_e shape;
    items_sent  = 0;
    restart_due = 1'b1;
    big_done    = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIRECTED[i].kind == STEP_WRITE) begin
        wait_idle();
        write_register(DIRECTED[i].idx, DIRECTED[i].data);
      end else begin
        send_pixel(DIRECTED[i].pix, DIRECTED[i].flush, DIRECTED[i].fixed, DIRECTED[i].res);
      end
    end

    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent < RANDOM_ITEMS / 3) begin
        send_idle_pct = 37;
        recv_idle_pct = 49;
      end else if (items_sent < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 49;
        recv_idle_pct = 37;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      // An oversized setting acts as the largest image; the first outputs follow the
      // column wrap.
      if (!big_done && items_sent >= 2 * RANDOM_ITEMS / 3) begin
        wait_idle();
        write_register(CFG_IMAGE_SIZE, 24'd2047);
        repeat (MAX_SIZE + 4) send_pixel(pick_pixel(), $urandom_range(0, 15) == 0, 1'b0, '0);
        items_sent += MAX_SIZE + 4;
        big_done    = 1'b1;
        restart_due = 1'b1;
      end

      if (restart_due || $urandom_range(0, 2) != 0) begin
        wait_idle();
        if ($urandom_range(0, 1)) write_register(CFG_KERNEL_TOP, pick_kernel());
        if ($urandom_range(0, 1)) write_register(CFG_KERNEL_MID, pick_kernel());
        if ($urandom_range(0, 1)) write_register(CFG_KERNEL_BOTTOM, pick_kernel());
        write_register(CFG_IMAGE_SIZE, KROW_W'(pick_side()));
        restart_due = 1'b0;
      end

      side = effective_size();
      case ($urandom_range(0, 7))
        6:       shape = SHAPE_CUT;
        7:       shape = SHAPE_NOISE;
        default: shape = SHAPE_FULL;
      endcase
      case (shape)
        SHAPE_CUT:   count = $urandom_range(0, side * side + side);
        SHAPE_NOISE: count = $urandom_range(1, 3 * side);
        default:     count = side * side + side + 1;
      endcase
      if (shape != SHAPE_FULL) restart_due = 1'b1;

      for (p = 0; p < count; p++) begin
        if (shape == SHAPE_NOISE) flush = $urandom_range(0, 1);
        else if (p < side * side) flush = ($urandom_range(0, 15) == 0);
        else flush = ($urandom_range(0, 7) != 0);
        if ($urandom_range(0, 255) == 0) wait_idle();
        send_pixel(pick_pixel(), flush, 1'b0, '0);
      end
      items_sent += count;
    end

    wait_idle();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/cv3_pkg.sv
hw/rtl/cv3_cell.sv
hw/rtl/cv3_line_store.sv
hw/rtl/conv2d_3x3_zero_padded_core.sv
tb/conv2d_3x3_zero_padded_core_test.sv
